// File: rtl/nava_pkg.sv
// shared types, constants and register codes for the nearest-atom voxel labeler
// no dependencies
`default_nettype none
package nava_pkg;

	localparam int POS_W       = 24;
	localparam int STEP_W      = 16;
	localparam int REACH_W     = 13;
	localparam int DIST_W      = 32;
	localparam int CNT_W       = 16;
	localparam int OUT_ID_W    = 16;
	localparam int IN_ID_W     = 16;
	localparam int RIDX_W      = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	// dividend of a box corner and its truncated quotient
	localparam int DVW         = 26;
	localparam int QW          = DVW + 1;
	// coordinate differences inside the grid (up to 1023 steps of 65535)
	localparam int CW          = 28;
	localparam int SQW         = 2 * CW;

	localparam int GRID_X_DEF       = 64;
	localparam int GRID_Y_DEF       = 64;
	localparam int GRID_Z_DEF       = 64;
	localparam int ATOM_ID_BITS_DEF = 16;

	localparam logic signed [POS_W-1:0] ORIGIN_RST = '0;
	localparam logic [STEP_W-1:0]       STEP_RST   = 16'd256;
	localparam logic [REACH_W-1:0]      REACH_RST  = 13'd768;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REACH    = 3'd6;

	localparam logic CMD_SPLAT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [2:0] LAST_CORNER = 3'd5;

	typedef struct packed {
		logic                    cmd;
		logic [IN_ID_W-1:0]      atom_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [RIDX_W-1:0]       voxel_index;
	} in_word_t;

	typedef struct packed {
		logic                 assigned;
		logic [OUT_ID_W-1:0]  nearest_atom;
		logic [DIST_W-1:0]    dist_sq;
		logic [CNT_W-1:0]     update_count;
	} out_word_t;

	typedef struct packed {
		logic                  start;
		logic signed [DVW-1:0] dividend;
		logic [STEP_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [QW-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DSTART,
		S_DWAIT,
		S_SETUP,
		S_WALK,
		S_DRAIN,
		S_READ,
		S_RDATA,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// File: rtl/nearest_atom_voxel_assign_top.sv
// top level of the nearest-atom voxel labeler: control, box walk and voxel store
// depends on nava_pkg, nava_div, nava_dist, nava_ram
`default_nettype none
// Keeps, for every voxel of a GRID_X x GRID_Y x GRID_Z grid, the nearest atom
// splatted so far and its squared distance, in one single-port-write memory with
// a registered read. After reset a clearing pass writes every voxel unassigned
// before the first word is taken; configuration writes are taken at any time.
// One word is in work at a time. A splat runs the six box-corner divisions in
// turn on the shared serial divider, passes a setup state, walks the in-grid
// voxels of the box (the read-modify-write pipeline visits one voxel per cycle),
// drains that pipeline and hands the result over; a read reads the memory and
// hands the result over. The result sits in an output register, so the next
// word is taken while a result waits.
module nearest_atom_voxel_assign_top import nava_pkg::*; #(
	parameter int GRID_X       = GRID_X_DEF,
	parameter int GRID_Y       = GRID_Y_DEF,
	parameter int GRID_Z       = GRID_Z_DEF,
	parameter int ATOM_ID_BITS = ATOM_ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NVOX = GRID_X * GRID_Y * GRID_Z;
	localparam int AW   = NVOX > 1 ? $clog2(NVOX) : 1;
	localparam int BX   = GRID_X > 1 ? $clog2(GRID_X) : 1;
	localparam int BY   = GRID_Y > 1 ? $clog2(GRID_Y) : 1;
	localparam int BZ   = GRID_Z > 1 ? $clog2(GRID_Z) : 1;
	localparam int IW   = (BX > BY) ? ((BX > BZ) ? BX : BZ) : ((BY > BZ) ? BY : BZ);
	localparam int EW   = 1 + ATOM_ID_BITS + DIST_W;

	state_t state_q, state_d;

	logic signed [POS_W-1:0] org_q [3];
	logic [STEP_W-1:0]       step_q [3];
	logic [REACH_W-1:0]      reach_q;
	logic [STEP_W-1:0]       st_eff [3];

	in_word_t                item_q;
	logic signed [POS_W-1:0] pos [3];

	logic [2:0]    k_q;
	logic [1:0]    ax;
	logic [IW-1:0] lo_q [3];
	logic [IW-1:0] hi_q [3];
	logic [2:0]    emp_q;
	logic          box_empty;

	logic [IW-1:0]          cur_q [3];
	logic signed [CW-1:0]   crd_q [3];
	logic signed [CW-1:0]   crd0_q [3];
	logic signed [CW-1:0]   crd_start [3];
	logic                   walk_last;

	logic                   v_s1, v_s2, v_s3;
	logic [AW-1:0]          addr_s1, addr_s2, addr_s3;
	logic signed [CW-1:0]   d_s1 [3];
	logic [DIST_W-1:0]      d2_s3;
	logic                   upd_s3;
	logic                   pipe_empty;

	logic [CNT_W-1:0]       cnt_q;
	logic [AW-1:0]          clr_q;
	logic                   clr_last;
	logic [AW-1:0]          rd_addr;
	logic                   rd_ok;

	out_word_t              res_q;
	out_word_t              out_q;
	logic                   out_valid_q;

	div_req_t               dreq;
	div_rsp_t               drsp;
	logic                   div_start;
	logic signed [QW-1:0]   dim_m1;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;

	// controls from the output decode
	logic                   take_item;
	logic                   walk_en;
	logic                   load_out;

	assign pos[0] = item_q.pos_x;
	assign pos[1] = item_q.pos_y;
	assign pos[2] = item_q.pos_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			st_eff[a]    = (step_q[a] == '0) ? STEP_W'(1) : step_q[a];
			crd_start[a] = CW'(org_q[a]) + $signed(CW'(lo_q[a]) * CW'(st_eff[a]));
		end
	end

	assign ax = k_q[2:1];

	// box corner dividend: pos -/+ reach - origin
	assign dreq.dividend = DVW'(DVW'(pos[ax]) - DVW'(org_q[ax]) +
	                       (k_q[0] ? $signed({1'b0, DVW'(reach_q)})
	                               : -$signed({1'b0, DVW'(reach_q)})));
	assign dreq.divisor  = st_eff[ax];
	assign dreq.start    = div_start;

	always_comb begin
		case (ax)
			2'd0:    dim_m1 = QW'(GRID_X - 1);
			2'd1:    dim_m1 = QW'(GRID_Y - 1);
			default: dim_m1 = QW'(GRID_Z - 1);
		endcase
	end

	nava_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign box_empty = (|emp_q) || (lo_q[0] > hi_q[0]) || (lo_q[1] > hi_q[1]) ||
	                   (lo_q[2] > hi_q[2]);
	assign walk_last = (cur_q[0] == hi_q[0]) && (cur_q[1] == hi_q[1]) &&
	                   (cur_q[2] == hi_q[2]);
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign clr_last   = clr_q == AW'(NVOX - 1);
	assign rd_addr    = AW'(item_q.voxel_index);
	assign rd_ok      = 32'(item_q.voxel_index) < 32'(NVOX);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:  if (clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.cmd == CMD_READ) ? S_READ : S_DSTART;
				end
			end
			S_DSTART: state_d = S_DWAIT;
			S_DWAIT: begin
				if (drsp.done) begin
					state_d = (k_q == LAST_CORNER) ? S_SETUP : S_DSTART;
				end
			end
			S_SETUP:  state_d = box_empty ? S_DRAIN : S_WALK;
			S_WALK:   if (walk_last) state_d = S_DRAIN;
			S_DRAIN:  if (pipe_empty) state_d = S_DONE;
			S_READ:   state_d = S_RDATA;
			S_RDATA:  state_d = S_DONE;
			S_DONE:   if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready   = 1'b0;
		div_start  = 1'b0;
		walk_en    = 1'b0;
		load_out   = 1'b0;
		ram_we     = upd_s3;
		ram_waddr  = addr_s3;
		ram_wdata  = {1'b1, ATOM_ID_BITS'(item_q.atom_id), d2_s3};
		ram_raddr  = addr_s2;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE:   in_ready = 1'b1;
			S_DSTART: div_start = 1'b1;
			S_WALK:   walk_en = 1'b1;
			S_READ:   ram_raddr = rd_addr;
			S_DONE:   load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign take_item = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	nava_ram #(
		.WIDTH (EW),
		.DEPTH (NVOX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nava_dist u_dist (
		.clk (clk),
		.dx  (d_s1[0]),
		.dy  (d_s1[1]),
		.dz  (d_s1[2]),
		.d2  (d2_s3)
	);

	// store entry at s3 lines up with the squared distance
	assign upd_s3 = v_s3 && (!ram_rdata[EW-1] || (d2_s3 < ram_rdata[DIST_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
			emp_q       <= '0;
			org_q[0]    <= ORIGIN_RST;
			org_q[1]    <= ORIGIN_RST;
			org_q[2]    <= ORIGIN_RST;
			step_q[0]   <= STEP_RST;
			step_q[1]   <= STEP_RST;
			step_q[2]   <= STEP_RST;
			reach_q     <= REACH_RST;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= walk_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (take_item) begin
				k_q   <= '0;
				cnt_q <= '0;
				emp_q <= '0;
			end else begin
				if (state_q == S_DWAIT && drsp.done) begin
					k_q <= k_q + 1'b1;
					if (!k_q[0] && drsp.quot > dim_m1) emp_q[ax] <= 1'b1;
					if (k_q[0] && drsp.quot < 0)       emp_q[ax] <= 1'b1;
				end
				if (upd_s3 && cnt_q != '1) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIGIN_X: org_q[0]  <= POS_W'(cfg_data);
					REG_ORIGIN_Y: org_q[1]  <= POS_W'(cfg_data);
					REG_ORIGIN_Z: org_q[2]  <= POS_W'(cfg_data);
					REG_STEP_X:   step_q[0] <= STEP_W'(cfg_data);
					REG_STEP_Y:   step_q[1] <= STEP_W'(cfg_data);
					REG_STEP_Z:   step_q[2] <= STEP_W'(cfg_data);
					REG_REACH:    reach_q   <= REACH_W'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_item) begin
			item_q <= in_data;
		end
		if (state_q == S_DWAIT && drsp.done) begin
			if (!k_q[0]) begin
				lo_q[ax] <= (drsp.quot < 0) ? '0 : IW'(drsp.quot);
			end else begin
				hi_q[ax] <= (drsp.quot > dim_m1) ? IW'(dim_m1) : IW'(drsp.quot);
			end
		end
		if (state_q == S_SETUP) begin
			for (int a = 0; a < 3; a++) begin
				cur_q[a]  <= lo_q[a];
				crd_q[a]  <= crd_start[a];
				crd0_q[a] <= crd_start[a];
			end
		end else if (walk_en) begin
			// z runs fastest, then y, then x
			if (cur_q[2] == hi_q[2]) begin
				cur_q[2] <= lo_q[2];
				crd_q[2] <= crd0_q[2];
				if (cur_q[1] == hi_q[1]) begin
					cur_q[1] <= lo_q[1];
					crd_q[1] <= crd0_q[1];
					cur_q[0] <= cur_q[0] + 1'b1;
					crd_q[0] <= crd_q[0] + $signed(CW'(st_eff[0]));
				end else begin
					cur_q[1] <= cur_q[1] + 1'b1;
					crd_q[1] <= crd_q[1] + $signed(CW'(st_eff[1]));
				end
			end else begin
				cur_q[2] <= cur_q[2] + 1'b1;
				crd_q[2] <= crd_q[2] + $signed(CW'(st_eff[2]));
			end
		end
		for (int a = 0; a < 3; a++) begin
			d_s1[a] <= CW'(pos[a]) - crd_q[a];
		end
		addr_s1 <= AW'(cur_q[0]) + AW'(GRID_X) * AW'(cur_q[1]) +
		           AW'(GRID_X * GRID_Y) * AW'(cur_q[2]);
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		if (state_q == S_DRAIN) begin
			res_q <= '{assigned: 1'b0, nearest_atom: '0, dist_sq: '0,
			           update_count: cnt_q};
		end else if (state_q == S_RDATA) begin
			if (rd_ok && ram_rdata[EW-1]) begin
				res_q <= '{assigned: 1'b1,
				           nearest_atom: OUT_ID_W'(ram_rdata[EW-2:DIST_W]),
				           dist_sq: ram_rdata[DIST_W-1:0],
				           update_count: '0};
			end else begin
				res_q <= '0;
			end
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: rtl/nava_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none
module nava_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/nava_div.sv
// sequential signed-by-unsigned divider, truncating toward zero, one bit per cycle
// depends on nava_pkg
`default_nettype none
module nava_div import nava_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_BITS = $clog2(DVW);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                neg_q;
	logic [DVW-1:0]      mag_q;
	logic [STEP_W-1:0]   rem_q;
	logic [STEP_W-1:0]   dsr_q;
	logic [STEP_W:0]     rsh;
	logic                ge;

	assign rsh = {rem_q, mag_q[DVW-1]};
	assign ge  = rsh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(DVW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[DVW-1];
			mag_q <= req.dividend[DVW-1] ? DVW'(-req.dividend) : DVW'(req.dividend);
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? STEP_W'(rsh - {1'b0, dsr_q}) : rsh[STEP_W-1:0];
			mag_q <= {mag_q[DVW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule
`default_nettype wire

// File: rtl/nava_dist.sv
// two-stage squared distance: three squarers, then sum with saturation to 32 bits
// depends on nava_pkg
`default_nettype none
module nava_dist import nava_pkg::*; (
	input  wire logic                 clk,
	input  wire logic signed [CW-1:0] dx,
	input  wire logic signed [CW-1:0] dy,
	input  wire logic signed [CW-1:0] dz,
	output logic         [DIST_W-1:0] d2
);

	logic signed [SQW-1:0] qx, qy, qz;
	logic [SQW-1:0]        qx_s2, qy_s2, qz_s2;
	logic [SQW+1:0]        sum;

	assign qx = dx * dx;
	assign qy = dy * dy;
	assign qz = dz * dz;
	assign sum = (SQW+2)'(qx_s2) + (SQW+2)'(qy_s2) + (SQW+2)'(qz_s2);

	always_ff @(posedge clk) begin
		qx_s2 <= qx;
		qy_s2 <= qy;
		qz_s2 <= qz;
		d2    <= (|sum[SQW+1:DIST_W]) ? '1 : sum[DIST_W-1:0];
	end

endmodule
`default_nettype wire

// File: rtl/nava_chk.sv
// port-level checker for the nearest-atom voxel labeler, bound to the top level
// depends on nava_pkg and nearest_atom_voxel_assign_top
`default_nettype none
module nava_chk import nava_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_word_t out_data,
	input wire logic      cfg_ready
);

	// a word in work blocks the next one
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word taken while another is in work");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel stalled");

	a_unassigned_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.assigned |->
		out_data.nearest_atom == '0 && out_data.dist_sq == '0)
		else $error("unassigned result carries voxel data");

	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.assigned |-> out_data.update_count == '0)
		else $error("read result carries an update count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind nearest_atom_voxel_assign_top nava_chk u_nava_chk (.*);
`default_nettype wire

// File: verif/nearest_atom_voxel_assign_top_tb.sv
// testbench for the nearest-atom voxel labeler: directed and random splats and reads
// checked word by word against an in-bench grid predictor; depends on nava_pkg and the rtl
`timescale 1ns / 1ps
module nearest_atom_voxel_assign_top_tb;
	import nava_pkg::*;

	localparam int GX = GRID_X_DEF;
	localparam int GY = GRID_Y_DEF;
	localparam int GZ = GRID_Z_DEF;
	localparam int NVOX = GX * GY * GZ;
	localparam int N_RANDOM = 730;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	class voxel_scoreboard;
		bit        grid_valid [NVOX];
		bit [15:0] grid_atom [NVOX];
		bit [31:0] grid_dist [NVOX];
		longint org_x, org_y, org_z;
		longint stp_x, stp_y, stp_z, half_box;
		out_word_t pending [$];
		int errors;

		function void clear();
			foreach (grid_valid[i]) grid_valid[i] = 0;
			org_x = 0; org_y = 0; org_z = 0;
			stp_x = 256; stp_y = 256; stp_z = 256;
			half_box = 768;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_ORIGIN_X: org_x = longint'(signed'(val));
				REG_ORIGIN_Y: org_y = longint'(signed'(val));
				REG_ORIGIN_Z: org_z = longint'(signed'(val));
				REG_STEP_X: stp_x = longint'(val[15:0]);
				REG_STEP_Y: stp_y = longint'(val[15:0]);
				REG_STEP_Z: stp_z = longint'(val[15:0]);
				REG_REACH: half_box = longint'(val[12:0]);
				default: ;
			endcase
		endfunction

		function void span(longint p, longint org, longint st, int dim,
				output longint lo, output longint hi);
			longint a, b;
			a = (p - half_box - org) / st;
			b = (p + half_box - org) / st;
			lo = a < 0 ? 0 : a;
			hi = b > dim - 1 ? dim - 1 : b;
		endfunction

		function void note_word(in_word_t w);
			out_word_t r;
			longint sx, sy, sz, x0, x1, y0, y1, z0, z1, px, py, pz, d, qx, qy, d2;
			int li;
			int unsigned cnt;
			bit [31:0] d32;
			r = '0;
			if (w.cmd == CMD_READ) begin
				if (w.voxel_index < NVOX && grid_valid[w.voxel_index]) begin
					r.assigned = 1'b1;
					r.nearest_atom = grid_atom[w.voxel_index];
					r.dist_sq = grid_dist[w.voxel_index];
				end
			end else begin
				sx = stp_x == 0 ? 1 : stp_x;
				sy = stp_y == 0 ? 1 : stp_y;
				sz = stp_z == 0 ? 1 : stp_z;
				px = longint'(w.pos_x); py = longint'(w.pos_y); pz = longint'(w.pos_z);
				span(px, org_x, sx, GX, x0, x1);
				span(py, org_y, sy, GY, y0, y1);
				span(pz, org_z, sz, GZ, z0, z1);
				cnt = 0;
				for (longint x = x0; x <= x1; x++) begin
					d = px - (org_x + x * sx); qx = d * d;
					for (longint y = y0; y <= y1; y++) begin
						d = py - (org_y + y * sy); qy = d * d;
						for (longint z = z0; z <= z1; z++) begin
							d = pz - (org_z + z * sz);
							d2 = qx + qy + d * d;
							d32 = d2 > 64'hFFFFFFFF ? 32'hFFFFFFFF : d2[31:0];
							li = int'(x + GX * (y + GY * z));
							if (!grid_valid[li] || d32 < grid_dist[li]) begin
								grid_valid[li] = 1'b1;
								grid_atom[li] = w.atom_id;
								grid_dist[li] = d32;
								if (cnt < 65535) cnt++;
							end
						end
					end
				end
				r.update_count = cnt[15:0];
			end
			pending.push_back(r);
		endfunction

		function void check_word(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected word %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.assigned !== e.assigned)
				$display("%0t assigned exp %0d got %0d", $time, e.assigned, got.assigned);
			if (got.nearest_atom !== e.nearest_atom)
				$display("%0t nearest_atom exp %0d got %0d", $time, e.nearest_atom,
					got.nearest_atom);
			if (got.dist_sq !== e.dist_sq)
				$display("%0t dist_sq exp %0d got %0d", $time, e.dist_sq, got.dist_sq);
			if (got.update_count !== e.update_count)
				$display("%0t update_count exp %0d got %0d", $time, e.update_count,
					got.update_count);
			if (got !== e) errors++;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_word_t in_data;
	out_word_t out_data;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	voxel_scoreboard sb;
	bit calm;

	nearest_atom_voxel_assign_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stall, check at each accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) sb.check_word(out_data);
			out_ready <= calm || ($urandom_range(99) >= 30);
		end
	end

	// valid stays up after a take when the next word follows at once
	task automatic send_word(in_word_t w);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 30) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(w);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_word_t splat(logic [15:0] id, int x, int y, int z);
		in_word_t w;
		w = '0;
		w.cmd = CMD_SPLAT;
		w.atom_id = id;
		w.pos_x = POS_W'(x); w.pos_y = POS_W'(y); w.pos_z = POS_W'(z);
		w.voxel_index = RIDX_W'($urandom);
		return w;
	endfunction

	function automatic in_word_t rd(int idx);
		in_word_t w;
		w = '0;
		w.cmd = CMD_READ;
		w.atom_id = IN_ID_W'($urandom);
		w.pos_x = POS_W'($urandom); w.pos_y = POS_W'($urandom); w.pos_z = POS_W'($urandom);
		w.voxel_index = RIDX_W'(idx);
		return w;
	endfunction

	// random word: half splats, mostly near the grid for the current setting, and half
	// reads of voxels in the grid or, rarely, beyond it
	function automatic in_word_t random_word(int span_lo, int span_hi);
		int k;
		k = $urandom_range(99);
		if (k < 45)
			return splat(16'($urandom), int'($urandom_range(span_hi)) - span_lo,
				int'($urandom_range(span_hi)) - span_lo,
				int'($urandom_range(span_hi)) - span_lo);
		else if (k < 50)
			return splat(16'($urandom), int'($urandom), int'($urandom), int'($urandom));
		else if (k < 95)
			return rd(int'($urandom_range(NVOX - 1)));
		return rd(int'($urandom_range(2 ** RIDX_W - 1, NVOX)));
	endfunction

	task automatic random_phase(int n, int span_lo, int span_hi);
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 3 && i < n / 2);
			send_word(random_word(span_lo, span_hi));
		end
		calm = 0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		calm = 0;
		arst_n = 0;
		in_valid = 0; in_data = '0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed, default setting
		send_word(rd(0));
		send_word(rd(NVOX - 1));
		send_word(rd(2 ** RIDX_W - 1));
		send_word(splat(16'hFFFF, 0, 0, 0));
		send_word(splat(16'h0001, 300, 300, 300));
		send_word(splat(16'h1234, 300, 300, 300));
		send_word(rd(0));
		send_word(rd(1 + GX + GX * GY));
		send_word(splat(16'hAAAA, 63 * 256, 63 * 256, 63 * 256));
		send_word(rd(NVOX - 1));
		send_word(splat(16'h5555, -8388608, 8388607, -8388608));
		send_word(splat(16'h00FF, 8388607, 8388607, 8388607));
		send_word(splat(16'h0F0F, -700, 16128, 500));
		drain();

		// wide reach, zero step, extreme origin: saturated distances
		write_reg(REG_REACH, 24'd4096);
		write_reg(REG_STEP_X, 24'd0);
		write_reg(REG_STEP_Y, 24'd65535);
		write_reg(REG_STEP_Z, 24'd100);
		write_reg(REG_ORIGIN_X, 24'h800000);
		write_reg(REG_ORIGIN_Y, 24'h7FFFFF);
		write_reg(REG_ORIGIN_Z, 24'hFFFF00);
		send_word(splat(16'h0202, -8388608 + 20, 8388607, 1000));
		send_word(splat(16'h0303, -8388608, 8388607 - 65535, -256));
		send_word(rd(5));
		send_word(rd(5 + GX * GY * 20));
		drain();
		write_reg(REG_UNUSED, 24'hABCDEF);
		write_reg(REG_STEP_X, 24'd65535);
		write_reg(REG_STEP_Y, 24'd1);
		write_reg(REG_STEP_Z, 24'd1);
		write_reg(REG_ORIGIN_X, 24'h7FFFFF);
		write_reg(REG_ORIGIN_Y, 24'h000000);
		write_reg(REG_ORIGIN_Z, 24'h000000);
		write_reg(REG_REACH, 24'd0);
		send_word(splat(16'h0404, 8388607, 10, 10));
		send_word(splat(16'h0505, 8388607, 10, 10));
		send_word(rd(10 * GX + 10 * GX * GY));
		drain();

		// back to the default grid
		write_reg(REG_STEP_X, 24'd256);
		write_reg(REG_STEP_Y, 24'd256);
		write_reg(REG_STEP_Z, 24'd256);
		write_reg(REG_ORIGIN_X, 24'h0);
		write_reg(REG_REACH, 24'd512);
		random_phase(N_RANDOM / 2, 1024, 64 * 256 + 1024);
		drain();

		write_reg(REG_STEP_X, 24'd97);
		write_reg(REG_STEP_Y, 24'd130);
		write_reg(REG_STEP_Z, 24'd64);
		write_reg(REG_ORIGIN_X, 24'hFFF000);
		write_reg(REG_ORIGIN_Y, 24'h000400);
		write_reg(REG_ORIGIN_Z, 24'hFFFF80);
		write_reg(REG_REACH, 24'd300);
		random_phase(N_RANDOM / 4, 4096, 8192);
		drain();

		write_reg(REG_STEP_X, 24'd4000);
		write_reg(REG_STEP_Y, 24'd4000);
		write_reg(REG_STEP_Z, 24'd4000);
		write_reg(REG_ORIGIN_X, 24'h0);
		write_reg(REG_ORIGIN_Y, 24'h0);
		write_reg(REG_ORIGIN_Z, 24'h0);
		write_reg(REG_REACH, 24'd1000);
		random_phase(N_RANDOM / 4, 2000, 64 * 4000);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
